### rtl/core/atbl_pkg.sv
`timescale 1ns / 1ps

package atbl_pkg;

  // Command codes carried by one input transaction
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_LAUNCH  = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } atbl_op_e;

  // Configuration register indexes
  localparam logic [1:0] REG_COMPUTE_LIMIT = 2'd0;
  localparam logic [1:0] REG_RATE_CAP      = 2'd1;
  localparam logic [1:0] REG_BURST_LIMIT   = 2'd2;

  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned VAL_W   = 31;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned OPB_W   = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_OFF   = 7'd100;
  localparam logic [WORD_W-1:0]  ADJ_GAIN    = 32'd50000;

  // Shared multiplier steps for the launch cost (five products)
  localparam int unsigned MUL_STEPS  = 5;
  // Divider retires RADIX_BITS quotient bits per cycle
  localparam int unsigned RADIX_BITS = 4;
  localparam int unsigned DIV_STEPS  = WORD_W / RADIX_BITS;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  // Datapath commands issued by the controller
  typedef struct packed {
    logic             load;
    logic             gain;
    logic             square;
    logic             div_step;
    logic             steer;
    logic             refill;
    logic             mul_step;
    logic [CNT_W-1:0] mul_sel;
    logic             check;
    logic             restart;
    logic             out_load;
  } atbl_cmd_t;

  // Datapath status seen by the controller
  typedef struct packed {
    atbl_op_e op;
    logic     limit_on;
    logic     usage_valid;
    logic     big;
  } atbl_stat_t;

endpackage

### rtl/core/atbl_ctrl.sv
`timescale 1ns / 1ps

module atbl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  atbl_pkg::atbl_stat_t stat_i,
  output atbl_pkg::atbl_cmd_t  cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_DECODE  = 11'b000_0000_0010,
    S_GAIN    = 11'b000_0000_0100,
    S_SQUARE  = 11'b000_0000_1000,
    S_DIV     = 11'b000_0001_0000,
    S_STEER   = 11'b000_0010_0000,
    S_REFILL  = 11'b000_0100_0000,
    S_MUL     = 11'b000_1000_0000,
    S_CHECK   = 11'b001_0000_0000,
    S_RESTART = 11'b010_0000_0000,
    S_DONE    = 11'b100_0000_0000
  } state_e;

  localparam logic [atbl_pkg::CNT_W-1:0] MulLast =
    atbl_pkg::CNT_W'(atbl_pkg::MUL_STEPS - 1);
  localparam logic [atbl_pkg::CNT_W-1:0] DivLast =
    atbl_pkg::CNT_W'(atbl_pkg::DIV_STEPS - 1);

  state_e                       state_q, state_d;
  logic [atbl_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;
  logic                         slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  // Sequence the datapath one transaction at a time
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cnt_d = '0;
        case (stat_i.op)
          atbl_pkg::OP_TICK: begin
            if (!stat_i.limit_on) begin
              state_d = S_DONE;
            end else if (stat_i.usage_valid) begin
              state_d = S_GAIN;
            end else begin
              state_d = S_REFILL;
            end
          end
          atbl_pkg::OP_LAUNCH:  state_d = S_MUL;
          atbl_pkg::OP_RESTART: state_d = S_RESTART;
          default:              state_d = S_DONE;
        endcase
      end
      S_GAIN: begin
        cmd_o.gain = 1'b1;
        state_d    = stat_i.big ? S_SQUARE : S_STEER;
      end
      S_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          state_d = S_STEER;
        end
      end
      S_STEER: begin
        cmd_o.steer = 1'b1;
        state_d     = S_REFILL;
      end
      S_REFILL: begin
        cmd_o.refill = 1'b1;
        state_d      = S_DONE;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_sel  = cnt_q;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == MulLast) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = S_DONE;
      end
      S_RESTART: begin
        cmd_o.restart = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the result until the output transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/core/atbl_dp.sv
`timescale 1ns / 1ps

module atbl_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  atbl_pkg::atbl_cmd_t   cmd_i,
  output atbl_pkg::atbl_stat_t  stat_o,
  input  logic                  cfg_valid_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [30:0]           cfg_data_i,
  input  logic [1:0]            command_i,
  input  logic                  usage_valid_i,
  input  logic [15:0]           group_usage_i,
  input  logic [30:0]           grid_x_i,
  input  logic [15:0]           grid_y_i,
  input  logic [15:0]           grid_z_i,
  input  logic [10:0]           block_x_i,
  input  logic [10:0]           block_y_i,
  input  logic [6:0]            block_z_i,
  output logic                  granted_o,
  output logic [30:0]           tokens_now_o,
  output logic [30:0]           rate_now_o
);

  localparam int unsigned LW = atbl_pkg::LIMIT_W;
  localparam int unsigned VW = atbl_pkg::VAL_W;
  localparam int unsigned WW = atbl_pkg::WORD_W;
  localparam int unsigned BW = atbl_pkg::OPB_W;

  // Configuration
  logic [LW-1:0] limit_q;
  logic [VW-1:0] cap_q, burst_q;

  // Bucket state
  logic [VW-1:0] tokens_q, tokens_d;
  logic [VW-1:0] rate_q, rate_d;

  // Captured transaction and working registers
  logic [1:0]    op_q;
  logic          uvalid_q;
  logic [BW-1:0] d_q;
  logic          big_q, up_q;
  logic [BW-1:0] gy_q, gz_q, bx_q, by_q, bz_q;
  logic [WW-1:0] acc_q, acc_d;
  logic [LW-1:0] rem_q, rem_d;
  logic          granted_q, granted_d;

  // Output stage
  logic          out_granted_q;
  logic [VW-1:0] out_tokens_q, out_rate_q;

  logic          limit_on;
  logic [BW-1:0] limit_ext, d_in;
  logic          up_in;
  logic [WW-1:0] mul_a;
  logic [BW-1:0] mul_b, dim_sel;
  logic [WW+BW-1:0] product;
  logic [LW:0]   divisor;
  logic [LW:0]   div_r;
  logic [WW-1:0] div_q;
  logic [WW-1:0] rate_ext, tokens_ext;
  logic [WW-1:0] up_sum, fill_sum;

  assign limit_on  = (limit_q != '0) && (limit_q < atbl_pkg::LIMIT_OFF);
  assign limit_ext = BW'(limit_q);
  assign up_in     = limit_ext > group_usage_i;
  assign d_in      = up_in ? (limit_ext - group_usage_i) : (group_usage_i - limit_ext);
  assign divisor   = {1'b0, limit_q} + 1'b1;
  assign rate_ext   = {1'b0, rate_q};
  assign tokens_ext = {1'b0, tokens_q};
  assign up_sum     = rate_ext + acc_q;
  assign fill_sum   = tokens_ext + rate_ext;

  assign stat_o.op          = atbl_pkg::atbl_op_e'(op_q);
  assign stat_o.limit_on    = limit_on;
  assign stat_o.usage_valid = uvalid_q;
  assign stat_o.big         = big_q;

  assign granted_o    = out_granted_q;
  assign tokens_now_o = out_tokens_q;
  assign rate_now_o   = out_rate_q;

  // Select the launch dimension for this multiply step
  always_comb begin
    case (cmd_i.mul_sel)
      3'd0:    dim_sel = gy_q;
      3'd1:    dim_sel = gz_q;
      3'd2:    dim_sel = bx_q;
      3'd3:    dim_sel = by_q;
      default: dim_sel = bz_q;
    endcase
  end

  // Shared multiplier, low word kept
  assign mul_a   = cmd_i.gain ? atbl_pkg::ADJ_GAIN : acc_q;
  assign mul_b   = cmd_i.mul_step ? dim_sel : d_q;
  assign product = mul_a * mul_b;

  // Retire RADIX_BITS quotient bits of the restoring divider
  always_comb begin
    div_r = {1'b0, rem_q};
    div_q = acc_q;
    for (int i = 0; i < int'(atbl_pkg::RADIX_BITS); i++) begin
      div_r = {div_r[LW-1:0], div_q[WW-1]};
      div_q = {div_q[WW-2:0], 1'b0};
      if (div_r >= divisor) begin
        div_r    = div_r - divisor;
        div_q[0] = 1'b1;
      end
    end
  end

  // Advance working registers and bucket state
  always_comb begin
    acc_d     = acc_q;
    rem_d     = rem_q;
    tokens_d  = tokens_q;
    rate_d    = rate_q;
    granted_d = granted_q;
    if (cmd_i.load) begin
      acc_d     = {1'b0, grid_x_i};
      granted_d = 1'b0;
    end
    if (cmd_i.gain || cmd_i.mul_step) begin
      acc_d = product[WW-1:0];
    end
    if (cmd_i.square) begin
      acc_d = {product[WW-2:0], 1'b0};
      rem_d = '0;
    end
    if (cmd_i.div_step) begin
      acc_d = div_q;
      rem_d = div_r[LW-1:0];
    end
    if (cmd_i.steer) begin
      if (up_q) begin
        rate_d = (up_sum > {1'b0, cap_q}) ? cap_q : up_sum[VW-1:0];
      end else begin
        rate_d = (rate_ext > acc_q) ? (rate_q - acc_q[VW-1:0]) : '0;
      end
    end
    if (cmd_i.refill) begin
      tokens_d = (fill_sum > {1'b0, burst_q}) ? burst_q : fill_sum[VW-1:0];
    end
    if (cmd_i.check) begin
      if (!limit_on) begin
        granted_d = 1'b1;
      end else if (tokens_ext >= acc_q) begin
        tokens_d  = tokens_q - acc_q[VW-1:0];
        granted_d = 1'b1;
      end
    end
    if (cmd_i.restart) begin
      tokens_d = burst_q;
      rate_d   = '0;
    end
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= atbl_pkg::LIMIT_OFF;
      cap_q    <= '0;
      burst_q  <= '0;
      tokens_q <= '0;
      rate_q   <= '0;
    end else begin
      tokens_q <= tokens_d;
      rate_q   <= rate_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          atbl_pkg::REG_COMPUTE_LIMIT: limit_q <= cfg_data_i[LW-1:0];
          atbl_pkg::REG_RATE_CAP:      cap_q   <= cfg_data_i;
          atbl_pkg::REG_BURST_LIMIT:   burst_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    rem_q     <= rem_d;
    granted_q <= granted_d;
    if (cmd_i.load) begin
      op_q     <= command_i;
      uvalid_q <= usage_valid_i;
      d_q      <= d_in;
      up_q     <= up_in;
      big_q    <= d_in > BW'(limit_q >> 1);
      gy_q     <= grid_y_i;
      gz_q     <= grid_z_i;
      bx_q     <= BW'(block_x_i);
      by_q     <= BW'(block_y_i);
      bz_q     <= BW'(block_z_i);
    end
    if (cmd_i.out_load) begin
      out_granted_q <= granted_q;
      out_tokens_q  <= tokens_q;
      out_rate_q    <= rate_q;
    end
  end

endmodule

### rtl/core/adaptive_token_bucket_limiter_top.sv
`timescale 1ns / 1ps

// Adaptive token bucket limiter. Each input transaction is a tick, a launch
// request or a bucket restart and yields one result transaction with the grant
// flag and the token count and fill rate after the command. One transaction is
// worked on at a time. An unused command or a tick with limiting off goes
// straight to the result. A restart runs the restart step, a tick without a
// usage sample the refill step, and a tick that steers the rate the gain, steer
// and refill steps, with the square step and the 4-bit-per-cycle divider before
// steer on the large difference path. A launch makes five passes through the
// shared 32x16 multiplier for the cost, then the grant check. A result waits
// while a stalled output still holds the last one. A finished result waits in
// an output register while the next command is taken. Configuration writes are
// always ready and take effect at once.
module adaptive_token_bucket_limiter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic        usage_valid_i,
  input  logic [15:0] group_usage_i,
  input  logic [30:0] grid_x_i,
  input  logic [15:0] grid_y_i,
  input  logic [15:0] grid_z_i,
  input  logic [10:0] block_x_i,
  input  logic [10:0] block_y_i,
  input  logic [6:0]  block_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        granted_o,
  output logic [30:0] tokens_now_o,
  output logic [30:0] rate_now_o
);

  atbl_pkg::atbl_cmd_t  cmd;
  atbl_pkg::atbl_stat_t stat;

  assign cfg_ready_o = 1'b1;

  atbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  atbl_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .command_i     (command_i),
    .usage_valid_i (usage_valid_i),
    .group_usage_i (group_usage_i),
    .grid_x_i      (grid_x_i),
    .grid_y_i      (grid_y_i),
    .grid_z_i      (grid_z_i),
    .block_x_i     (block_x_i),
    .block_y_i     (block_y_i),
    .block_z_i     (block_z_i),
    .granted_o     (granted_o),
    .tokens_now_o  (tokens_now_o),
    .rate_now_o    (rate_now_o)
  );

`ifndef NO_ASSERTIONS
  // One transaction in flight: ready drops right after an accept
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a transaction was in flight");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("result register loaded while still full");

  // The divider runs only with limiting active, so the divisor is sane
  a_div_limited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> stat.limit_on && stat.big)
    else $error("divider stepped outside a large steering adjustment");
`endif

endmodule
